// ===== rtl/lse_pkg.sv =====
package lse_pkg;

  // pixel and result widths
  localparam int PIXEL_W = 24;
  localparam int VALUE_W = 32;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 6;

  // bit positions of the band LSBs inside a packed pixel
  localparam int RED_LSB   = 16;
  localparam int GREEN_LSB = 8;
  localparam int BLUE_LSB  = 0;

  // band rotation codes
  localparam logic [1:0] BAND_RED   = 2'd0;
  localparam logic [1:0] BAND_GREEN = 2'd1;
  localparam logic [1:0] BAND_BLUE  = 2'd2;

  // bits per item in each phase
  localparam logic [COUNT_W-1:0] BYTE_BITS   = 6'd8;
  localparam logic [COUNT_W-1:0] LENGTH_BITS = 6'd32;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_NAME    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_IDLE    = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

endpackage

// ===== rtl/lse_core.sv =====
module lse_core import lse_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,      // a pixel word is taken this cycle
  input  logic [PIXEL_W-1:0]  pixel,
  output logic                res_valid, // this pixel completes an item
  output result_t             res
);

  phase_t             phase, phase_next;
  logic [1:0]         band_select, band_select_next;
  logic [COUNT_W-1:0] bit_count, bit_count_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [VALUE_W-1:0] bytes_remaining, bytes_remaining_next;

  logic               bit_in;
  logic [VALUE_W-1:0] acc_shift;
  logic [COUNT_W-1:0] cnt_inc;
  logic               active;

  // pick the LSB of the current band; the unused code reads as red
  always_comb begin
    case (band_select)
      BAND_GREEN: bit_in = pixel[GREEN_LSB];
      BAND_BLUE:  bit_in = pixel[BLUE_LSB];
      default:    bit_in = pixel[RED_LSB];
    endcase
  end

  assign acc_shift = {accumulator[VALUE_W-2:0], bit_in};
  assign cnt_inc   = bit_count + 6'd1;
  assign active    = step && (phase != PH_IDLE);

  // next state
  always_comb begin
    phase_next           = phase;
    band_select_next     = band_select;
    bit_count_next       = bit_count;
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    if (active) begin
      band_select_next = (band_select >= BAND_BLUE) ? BAND_RED : band_select + 2'd1;
      accumulator_next = acc_shift;
      bit_count_next   = cnt_inc;
      case (phase)
        PH_NAME: begin
          if (cnt_inc == BYTE_BITS) begin
            bit_count_next   = '0;
            accumulator_next = '0;
            if (acc_shift[BYTE_W-1:0] == '0) phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (cnt_inc == LENGTH_BITS) begin
            bit_count_next       = '0;
            accumulator_next     = '0;
            bytes_remaining_next = acc_shift;
            phase_next           = (acc_shift == '0) ? PH_IDLE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (cnt_inc == BYTE_BITS) begin
            bit_count_next       = '0;
            accumulator_next     = '0;
            bytes_remaining_next = bytes_remaining - 32'd1;
            if (bytes_remaining == 32'd1) phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // result for the pixel being taken
  always_comb begin
    res_valid = 1'b0;
    res.kind  = KIND_NAME;
    res.value = {{(VALUE_W-BYTE_W){1'b0}}, acc_shift[BYTE_W-1:0]};
    res.last  = 1'b0;
    if (active) begin
      case (phase)
        PH_NAME: begin
          res_valid = (cnt_inc == BYTE_BITS);
          res.kind  = KIND_NAME;
          res.last  = (acc_shift[BYTE_W-1:0] == '0);
        end
        PH_LENGTH: begin
          res_valid = (cnt_inc == LENGTH_BITS);
          res.kind  = KIND_LENGTH;
          res.value = acc_shift;
          res.last  = (acc_shift == '0);
        end
        PH_PAYLOAD: begin
          res_valid = (cnt_inc == BYTE_BITS);
          res.kind  = KIND_PAYLOAD;
          res.last  = (bytes_remaining == 32'd1);
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_NAME;
      band_select     <= BAND_RED;
      bit_count       <= '0;
      accumulator     <= '0;
      bytes_remaining <= '0;
    end else begin
      phase           <= phase_next;
      band_select     <= band_select_next;
      bit_count       <= bit_count_next;
      accumulator     <= accumulator_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ===== rtl/lse_out_buf.sv =====
module lse_out_buf import lse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  output logic    room,      // skid stage empty: a new word may enter
  input  logic    push,
  input  result_t push_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    main_valid, skid_valid;
  result_t main_res, skid_res;
  logic    pop;

  assign room      = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;
  assign pop       = main_valid && out_ready;

  // control: main register feeds the port, skid catches a word on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop || !main_valid) begin
        main_valid <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop || !main_valid) begin
      main_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

// ===== rtl/lsb_stego_extractor.sv =====
// LSB steganography extractor for a stream of packed RGB pixels.
// s_axis takes one 24-bit pixel word per cycle (red 23:16, green 15:8,
// blue 7:0). Bands are read in rotation red, green, blue, one per pixel,
// and the LSB of that band is shifted in MSB first.
// m_axis gives: name characters (tuser 0) up to and including the zero
// byte, then the 32-bit payload length (tuser 1), then that many payload
// bytes (tuser 2). tlast marks the zero name byte, a zero length, or the
// final payload byte. After that, pixels are taken and dropped.
// Throughput: one pixel per cycle while the output buffer has room.
// A result enters the output register, or the skid stage if that is held,
// when its completing pixel is taken. A two-word output buffer (output
// register plus skid stage) lets pixels keep flowing while a result waits;
// s_axis_tready drops only when both words are held by a stalled receiver.
// Reset (rst, synchronous) returns to the name phase with the red band,
// clears the bit counter and accumulator and empties the output buffer.
module lsb_stego_extractor import lse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel[23:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // value[31:0]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);

  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    room;

  assign s_axis_tready = room;
  assign step          = s_axis_tvalid && room;

  lse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pixel     (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lse_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .room      (room),
    .push      (res_valid),
    .push_res  (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res.value;
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== tb/sv/lsb_stego_extractor_tb.sv =====
`timescale 1ns / 1ps

module lsb_stego_extractor_tb import lse_pkg::*;;

  localparam int PIXEL_BUDGET = 1800;
  localparam int IDLE_PIXELS  = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  // message layouts; the block only runs one message per reset
  localparam int MSG_ZERO_LEN = 0;
  localparam int MSG_LONG_LEN = 3;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // pixel[23:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // value[31:0]
  logic [1:0]  m_axis_tuser;         // kind[1:0]
  logic        m_axis_tlast;

  lsb_stego_extractor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // pixels waiting to be sent, and decoded words waiting to come out
  logic [23:0] pixel_q[$];
  result_t     decoded_q[$];

  int pixels_taken = 0;
  int total_pixels = 1;
  int words_seen   = 0;
  int errors       = 0;
  int cycles       = 0;
  int embed_band   = 0;

  // decoder state, starts at its reset values
  logic [1:0]  band      = BAND_RED;
  logic [5:0]  nbits     = '0;
  logic [31:0] shreg     = '0;
  phase_t      ph        = PH_NAME;
  logic [31:0] left      = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hide bits MSB first in the band LSB of successive pixels
  task automatic embed_bits(input logic [31:0] v, input int n, input bit extreme);
    logic [23:0] px;
    int lsb;
    for (int i = n - 1; i >= 0; i--) begin
      lsb = (embed_band == 1) ? GREEN_LSB : (embed_band == 2) ? BLUE_LSB : RED_LSB;
      if (extreme)
        px = v[i] ? 24'hFF_FFFF : 24'h00_0000;
      else
        px = 24'($urandom);
      px[lsb] = v[i];
      pixel_q.push_back(px);
      embed_band = (embed_band == 2) ? 0 : embed_band + 1;
    end
  endtask

  // decode one taken pixel into the words the block should emit
  task automatic decode_pixel(input logic [23:0] px);
    logic    b;
    result_t w;
    if (ph == PH_IDLE)
      return;
    case (band)
      BAND_GREEN: b = px[GREEN_LSB];
      BAND_BLUE:  b = px[BLUE_LSB];
      default:    b = px[RED_LSB];
    endcase
    band  = (band == BAND_BLUE) ? BAND_RED : band + 2'd1;
    shreg = {shreg[30:0], b};
    nbits = nbits + 6'd1;
    case (ph)
      PH_NAME: begin
        if (nbits == BYTE_BITS) begin
          w.kind  = KIND_NAME;
          w.value = {24'd0, shreg[7:0]};
          w.last  = (shreg[7:0] == 8'd0);
          if (w.last)
            ph = PH_LENGTH;
          nbits = '0;
          shreg = '0;
          decoded_q.push_back(w);
        end
      end
      PH_LENGTH: begin
        if (nbits == LENGTH_BITS) begin
          w.kind  = KIND_LENGTH;
          w.value = shreg;
          w.last  = (shreg == 32'd0);
          left    = shreg;
          ph      = w.last ? PH_IDLE : PH_PAYLOAD;
          nbits   = '0;
          shreg   = '0;
          decoded_q.push_back(w);
        end
      end
      default: begin
        if (nbits == BYTE_BITS) begin
          left    = left - 32'd1;
          w.kind  = KIND_PAYLOAD;
          w.value = {24'd0, shreg[7:0]};
          w.last  = (left == 32'd0);
          if (w.last)
            ph = PH_IDLE;
          nbits = '0;
          shreg = '0;
          decoded_q.push_back(w);
        end
      end
    endcase
  endtask

  // stall percentage per side: busy receiver, then busy sender, then none
  function automatic int stall_pct(input bit sender);
    int seg;
    seg = (pixels_taken * 3) / total_pixels;
    case (seg)
      0:       return sender ? 33 : 57;
      1:       return sender ? 57 : 33;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at word %0d, %0s: got %h, want %h", words_seen, what, got, want);
    errors++;
  endtask

  // build the message, release reset, wait for the drain
  initial begin : stim
    int          layout;
    int          nchars;
    int          nbytes;
    logic [31:0] len;
    logic [7:0]  ch;

    layout = $urandom_range(0, 3);
    nchars = (layout == MSG_ZERO_LEN) ? (PIXEL_BUDGET - 32) / 8 - 1 : $urandom_range(3, 40);
    nbytes = (layout == MSG_ZERO_LEN) ? 0 : (PIXEL_BUDGET - 32 - 8 * (nchars + 1)) / 8;

    // name: extreme characters first, the first one on all-zero / all-one pixels
    for (int i = 0; i < nchars; i++) begin
      ch = (i == 0) ? 8'hFF : (i == 1) ? 8'h01 : (i == 2) ? 8'h80 : 8'($urandom_range(1, 255));
      embed_bits({24'd0, ch}, 8, i == 0);
    end
    embed_bits(32'd0, 8, 1'b1);

    // length: zero, exact, or too large to ever finish
    if (layout == MSG_ZERO_LEN)
      len = 32'd0;
    else if (layout == MSG_LONG_LEN)
      len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : (32'h8000_0000 | $urandom);
    else
      len = nbytes;
    embed_bits(len, 32, 1'b0);

    for (int j = 0; j < nbytes; j++) begin
      ch = (j == 0) ? 8'h00 : (j == 1) ? 8'hFF : 8'($urandom);
      embed_bits({24'd0, ch}, 8, 1'b0);
    end

    // once idle, pixels are taken and dropped
    if (layout != MSG_LONG_LEN)
      repeat (IDLE_PIXELS) pixel_q.push_back(24'($urandom));
    total_pixels = pixel_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (!(pixels_taken == total_pixels && decoded_q.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_pixel(s_axis_tdata);
        pixels_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= stall_pct(1'b1)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // word monitor and checker
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 32'd0);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("kind", {30'd0, m_axis_tuser}, {30'd0, want.kind});
          if (m_axis_tdata !== want.value)
            report_mismatch("value", m_axis_tdata, want.value);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", {31'd0, m_axis_tlast}, {31'd0, want.last});
        end
        words_seen++;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct(1'b0));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
